[rtl/core/a2cs_pkg.sv]
// ----------------------------------------------------------------------------
// a2cs_pkg
// Shared widths, register indexes, reset values and sequencer states of the
// angle to channel shaper.
// ----------------------------------------------------------------------------
package a2cs_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 6;

    localparam int ANGLE_W    = 16;
    localparam int GAIN_W     = 12;
    localparam int BETA_W     = 7;
    localparam int US_W       = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int FV_W   = 32;
    localparam int MB_W   = 32;
    localparam int PROD_W = FV_W + MB_W;
    localparam int ACC_W  = 40;
    localparam int REM_W  = 40;
    localparam int Q_W    = 32;

    localparam int BETA_FULL = 100;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_GAIN   = 3'd0;
    localparam t_cfg_idx REG_REVERSE = 3'd1;
    localparam t_cfg_idx REG_BETA   = 3'd2;
    localparam t_cfg_idx REG_CENTER = 3'd3;
    localparam t_cfg_idx REG_MIN    = 3'd4;
    localparam t_cfg_idx REG_MAX    = 3'd5;
    localparam t_cfg_idx REG_WRAP   = 3'd6;

    localparam logic [GAIN_W-1:0] GAIN_RST   = 12'd320;
    localparam logic [BETA_W-1:0] BETA_RST   = 7'd100;
    localparam logic [US_W-1:0]   CENTER_RST = 12'd1500;
    localparam logic [US_W-1:0]   MIN_RST    = 12'd1000;
    localparam logic [US_W-1:0]   MAX_RST    = 12'd2000;

    localparam logic signed [FV_W-1:0] FV_SAT = 32'sh7FFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FOLD,
        ST_FIX,
        ST_MUL_G,
        ST_MUL_F,
        ST_MUL_X,
        ST_SUM,
        ST_PREP,
        ST_RCP,
        ST_BACK,
        ST_DIV,
        ST_FILT,
        ST_OUT
    } t_state;

endpackage

[rtl/core/a2cs_ifs.sv]
// ----------------------------------------------------------------------------
// a2cs channel interfaces
// Valid/ready channels of the shaper: angle beats in, channel beats out and
// register writes.
// ----------------------------------------------------------------------------
interface a2cs_in_if;
    import a2cs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;
    logic                      zero_request;

    modport source (output valid, angle, zero_request, input ready);
    modport sink   (input valid, angle, zero_request, output ready);
endinterface

interface a2cs_out_if;
    import a2cs_pkg::*;
    logic            valid;
    logic            ready;
    logic [US_W-1:0] channel_us;

    modport source (output valid, channel_us, input ready);
    modport sink   (input valid, channel_us, output ready);
endinterface

interface a2cs_cfg_if;
    import a2cs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/angle_to_channel_shaper.sv]
// ----------------------------------------------------------------------------
// angle_to_channel_shaper
// One tracker axis: zero offset, optional half-turn fold, gain, reverse,
// first-order low-pass, centre offset and clamp to a pulse width in us.
//
// Usage:
//   i_in  : angle beats (angle, zero_request). One beat is taken only when
//           the sequencer is idle; ready drops for the whole computation.
//   o_out : one channel_us beat per input beat, held in an output register.
//           A stalled receiver holds that beat; the next input is still
//           taken and worked on, and its result waits until the slot frees.
//   i_cfg : register writes (index, data), always ready. Write only while
//           no beat is in flight.
// The sequencer steps one single shared 32x32 multiplier (gain, both filter
//   taps, reciprocal of 100 and back-multiply) and one shared compare/subtract
//   unit (half-turn fold and the two-step remainder fix-up of the divide
//   by 100) through the computation; wrap mode adds the fold steps.
// Reset: synchronous active low; registers return to their reset values,
//   zero offset and filter state clear, output beat dropped.
// ----------------------------------------------------------------------------
module angle_to_channel_shaper #(
    parameter int ANGLE_WIDTH = a2cs_pkg::ANGLE_WIDTH_DEF,
    parameter int FRAC_BITS   = a2cs_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    a2cs_in_if.sink     i_in,
    a2cs_out_if.source  o_out,
    a2cs_cfg_if.sink    i_cfg
);
    import a2cs_pkg::*;

    localparam int SCALE_FRAC = FRAC_BITS + 6;
    localparam int KMAX = (ANGLE_WIDTH > FRAC_BITS + 8) ? ANGLE_WIDTH - FRAC_BITS - 8 : 0;
    localparam int SUM_W = FV_W + 2;
    localparam int RCP_SH    = 7;
    localparam int RCP_FRAC  = 30;
    localparam int DIV_STEPS = 2;

    localparam logic signed [REM_W-1:0] HALF     = REM_W'(180 * (2 ** FRAC_BITS));
    localparam logic signed [REM_W-1:0] FULL     = REM_W'(360 * (2 ** FRAC_BITS));
    localparam logic signed [REM_W-1:0] FULL_TOP = FULL <<< KMAX;
    localparam logic signed [REM_W-1:0] DIV_BASE = REM_W'(BETA_FULL);
    localparam logic signed [REM_W-1:0] DIV_TOP  = DIV_BASE <<< (DIV_STEPS - 1);
    localparam logic signed [REM_W-1:0] RND_HALF = REM_W'(BETA_FULL / 2);
    localparam logic signed [MB_W-1:0]  RCP_K    =
        MB_W'((64'sd1 <<< (RCP_FRAC + RCP_SH)) / BETA_FULL);
    localparam logic signed [MB_W-1:0]  DIV_MUL  = MB_W'(BETA_FULL);
    localparam logic [DIV_STEPS-1:0]    QW_TOP   = DIV_STEPS'(2 ** (DIV_STEPS - 1));
    localparam logic signed [SUM_W-1:0] TRUNC_ADJ =
        SUM_W'((64'sd1 <<< SCALE_FRAC) - 64'sd1);

    // configuration
    logic [GAIN_W-1:0] r_gain;
    logic              r_rev;
    logic [BETA_W-1:0] r_beta;
    logic [US_W-1:0]   r_center;
    logic [US_W-1:0]   r_min;
    logic [US_W-1:0]   r_max;
    logic              r_wrap;

    // sequencer and datapath
    t_state                        r_state, n_state;
    logic signed [ANGLE_WIDTH-1:0] r_off, n_off;
    logic signed [REM_W-1:0]       r_rem, n_rem;
    logic signed [REM_W-1:0]       r_sub, n_sub;
    logic [Q_W-1:0]                r_q, n_q;
    logic [DIV_STEPS-1:0]          r_qw, n_qw;
    logic                          r_neg, n_neg;
    logic signed [PROD_W-1:0]      r_prod, n_prod;
    logic signed [FV_W-1:0]        r_x, n_x;
    logic signed [ACC_W-1:0]       r_acc, n_acc;
    logic signed [FV_W-1:0]        r_fv, n_fv;
    logic                          r_out_valid, n_out_valid;
    logic [US_W-1:0]               r_out_data, n_out_data;

    // angle capture
    logic [ANGLE_W+ANGLE_WIDTH-1:0] ang_ext;
    logic signed [ANGLE_WIDTH-1:0]  ang;
    logic signed [ANGLE_WIDTH-1:0]  off_sel;
    logic signed [ANGLE_WIDTH:0]    ang_diff;
    logic signed [REM_W-1:0]        diff_ext;

    // shared compare/subtract unit
    logic                    cs_ge;
    logic signed [REM_W-1:0] cs_res;
    logic signed [REM_W-1:0] fix_rem;

    // shared multiplier
    logic [BETA_W-1:0]        beta_eff;
    logic [BETA_W-1:0]        beta_rest;
    logic signed [FV_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;

    logic signed [FV_W-1:0]  sat_val;
    logic signed [FV_W-1:0]  x_sat;
    logic signed [ACC_W-1:0] acc_mag;

    // output stage
    logic signed [SUM_W-1:0] s_sum;
    logic signed [SUM_W-1:0] s_adj;
    logic signed [SUM_W-1:0] v_us;
    logic signed [SUM_W-1:0] max_s;
    logic signed [SUM_W-1:0] min_s;
    logic signed [SUM_W-1:0] v_hi;
    logic signed [SUM_W-1:0] v_lim;

    assign ang_ext  = {{ANGLE_WIDTH{1'b0}}, i_in.angle};
    assign ang      = ang_ext[ANGLE_WIDTH-1:0];
    assign off_sel  = i_in.zero_request ? ang : r_off;
    assign ang_diff = (ANGLE_WIDTH+1)'(ang) - (ANGLE_WIDTH+1)'(off_sel);
    assign diff_ext = REM_W'(ang_diff);

    assign cs_ge   = (r_rem >= r_sub);
    assign cs_res  = cs_ge ? r_rem - r_sub : (r_rem[REM_W-1] ? r_rem + r_sub : r_rem);
    assign fix_rem = (r_rem[REM_W-1] ? r_rem + FULL : r_rem) - HALF;

    assign beta_eff  = (r_beta > BETA_W'(BETA_FULL)) ? BETA_W'(BETA_FULL) : r_beta;
    assign beta_rest = BETA_W'(BETA_FULL) - beta_eff;

    always_comb begin
        case (r_state)
            ST_MUL_G: begin
                mul_a = r_rem[FV_W-1:0];
                mul_b = $signed({{(MB_W-GAIN_W){1'b0}}, r_gain});
            end
            ST_MUL_F: begin
                mul_a = r_fv;
                mul_b = $signed({{(MB_W-BETA_W){1'b0}}, beta_rest});
            end
            ST_MUL_X: begin
                mul_a = r_x;
                mul_b = $signed({{(MB_W-BETA_W){1'b0}}, beta_eff});
            end
            ST_RCP: begin
                mul_a = $signed(r_rem[RCP_SH +: FV_W]);
                mul_b = RCP_K;
            end
            ST_BACK: begin
                mul_a = $signed(r_q);
                mul_b = DIV_MUL;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign sat_val = (r_prod > PROD_W'(FV_SAT))  ? FV_SAT :
                     (r_prod < -PROD_W'(FV_SAT)) ? -FV_SAT : r_prod[FV_W-1:0];
    assign x_sat   = r_rev ? -sat_val : sat_val;
    assign acc_mag = r_acc[ACC_W-1] ? -r_acc : r_acc;

    assign s_sum = SUM_W'(r_fv) + (SUM_W'($signed({1'b0, r_center})) <<< SCALE_FRAC);
    assign s_adj = s_sum[SUM_W-1] ? s_sum + TRUNC_ADJ : s_sum;
    assign v_us  = s_adj >>> SCALE_FRAC;
    assign max_s = SUM_W'($signed({1'b0, r_max}));
    assign min_s = SUM_W'($signed({1'b0, r_min}));
    assign v_hi  = (v_us > max_s) ? max_s : v_us;
    assign v_lim = (v_hi < min_s) ? min_s : v_hi;

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.channel_us = r_out_data;
    assign i_cfg.ready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RST;
            r_rev    <= 1'b0;
            r_beta   <= BETA_RST;
            r_center <= CENTER_RST;
            r_min    <= MIN_RST;
            r_max    <= MAX_RST;
            r_wrap   <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GAIN:    r_gain   <= i_cfg.data[GAIN_W-1:0];
                REG_REVERSE: r_rev    <= i_cfg.data[0];
                REG_BETA:    r_beta   <= i_cfg.data[BETA_W-1:0];
                REG_CENTER:  r_center <= i_cfg.data[US_W-1:0];
                REG_MIN:     r_min    <= i_cfg.data[US_W-1:0];
                REG_MAX:     r_max    <= i_cfg.data[US_W-1:0];
                REG_WRAP:    r_wrap   <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_off       = r_off;
        n_rem       = r_rem;
        n_sub       = r_sub;
        n_q         = r_q;
        n_qw        = r_qw;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_x         = r_x;
        n_acc       = r_acc;
        n_fv        = r_fv;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_off   = off_sel;
                    n_rem   = r_wrap ? diff_ext + HALF : diff_ext;
                    n_sub   = FULL_TOP;
                    n_state = r_wrap ? ST_FOLD : ST_MUL_G;
                end
            end
            ST_FOLD: begin
                n_rem = cs_res;
                n_sub = r_sub >>> 1;
                if (r_sub == FULL) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                n_rem   = fix_rem;
                n_state = ST_MUL_G;
            end
            ST_MUL_G: begin
                n_prod  = mul_p;
                n_state = ST_MUL_F;
            end
            ST_MUL_F: begin
                n_x     = x_sat;
                n_prod  = mul_p;
                n_state = ST_MUL_X;
            end
            ST_MUL_X: begin
                n_acc   = ACC_W'(r_prod);
                n_prod  = mul_p;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_acc   = r_acc + ACC_W'(r_prod);
                n_state = ST_PREP;
            end
            ST_PREP: begin
                n_neg   = r_acc[ACC_W-1];
                n_rem   = acc_mag + RND_HALF;
                n_state = ST_RCP;
            end
            // quotient estimate, low by at most 3
            ST_RCP: begin
                n_q     = mul_p[RCP_FRAC +: Q_W];
                n_state = ST_BACK;
            end
            ST_BACK: begin
                n_rem   = r_rem - REM_W'(mul_p);
                n_sub   = DIV_TOP;
                n_qw    = QW_TOP;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = cs_res;
                n_sub = r_sub >>> 1;
                n_qw  = r_qw >> 1;
                n_q   = r_q + (cs_ge ? Q_W'(r_qw) : '0);
                if (r_sub == DIV_BASE) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                n_fv    = r_neg ? -$signed(r_q) : $signed(r_q);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = v_lim[US_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_off       <= '0;
            r_fv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_off       <= n_off;
            r_fv        <= n_fv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_sub      <= n_sub;
        r_q        <= n_q;
        r_qw       <= n_qw;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
        r_x        <= n_x;
        r_acc      <= n_acc;
        r_out_data <= n_out_data;
    end

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while sequencer busy");

    a_div_rem_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !r_rem[REM_W-1])
        else $error("divide remainder went negative");

    a_fold_sub_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD) |-> (r_sub >= FULL))
        else $error("fold step below one turn");

    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILT) |-> !r_q[Q_W-1])
        else $error("filter quotient overflow");

    a_fv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fv >= -FV_SAT)
        else $error("filter state out of range");

endmodule

[tb/angle_to_channel_shaper_tb.sv]
// ----------------------------------------------------------------------------
// angle_to_channel_shaper_tb
// Self-checking bench for one tracker axis. Angle beats are driven from a
// queue and predicted on acceptance by a behavioural copy of the offset,
// fold, gain, low-pass and clamp path. Channel beats are checked in order.
// Directed extremes come first, then random settings and angles, with random
// idling on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module angle_to_channel_shaper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import a2cs_pkg::*;

    localparam t_cfg_idx REG_SPARE = 3'd7;

    localparam longint HALF_TURN  = 180 * (longint'(1) << FRAC_BITS_DEF);
    localparam longint FULL_TURN  = 2 * HALF_TURN;
    localparam longint US_ONE     = longint'(1) << (FRAC_BITS_DEF + 6);
    localparam longint SAT_LIMIT  = 64'sd2147483647;

    localparam int N_RAND_PHASES    = 11;
    localparam int BEATS_PER_PHASE  = 160;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 60;

    typedef struct {
        logic signed [ANGLE_W-1:0] angle;
        logic                      zero_request;
    } t_beat;

    logic clk;
    logic rst_n;

    a2cs_in_if  in_if();
    a2cs_out_if out_if();
    a2cs_cfg_if cfg_if();

    angle_to_channel_shaper u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // shadow settings and axis state
    logic [GAIN_W-1:0]         gain_q;
    logic                      reverse_q;
    logic [BETA_W-1:0]         beta_q;
    logic [US_W-1:0]           center_q;
    logic [US_W-1:0]           min_us_q;
    logic [US_W-1:0]           max_us_q;
    logic                      wrap_q;
    logic signed [ANGLE_W-1:0] angle_zero;
    logic signed [FV_W-1:0]    filt_state;

    t_beat           beats_pending[$];
    logic [US_W-1:0] channel_expected[$];

    t_beat           next_beat;
    logic [US_W-1:0] want_us;
    bit              idle_en = 1'b1;
    int              n_queued;
    int              n_in_beats;
    int              n_checked;
    int              n_err;
    int              src_gap;
    int              sink_gap;
    int              long_hold;
    bit              long_hold_done;
    int              quiet;

    function automatic logic [US_W-1:0] shape_angle(input logic signed [ANGLE_W-1:0] ang,
                                                    input logic zero_req);
        longint d;
        longint x;
        longint b;
        longint num;
        longint y;
        longint v;
        if (zero_req)
            angle_zero = ang;
        d = longint'(ang) - longint'(angle_zero);
        if (wrap_q) begin
            d = (d + HALF_TURN) % FULL_TURN;
            if (d < 0)
                d = d + FULL_TURN;
            d = d - HALF_TURN;
        end
        x = d * longint'(gain_q);
        if (x > SAT_LIMIT)
            x = SAT_LIMIT;
        else if (x < -SAT_LIMIT)
            x = -SAT_LIMIT;
        if (reverse_q)
            x = -x;
        b = longint'(beta_q);
        if (b > BETA_FULL)
            b = BETA_FULL;
        num = b * x + (BETA_FULL - b) * longint'(filt_state);
        if (num >= 0)
            y = (num + BETA_FULL / 2) / BETA_FULL;
        else
            y = -((-num + BETA_FULL / 2) / BETA_FULL);
        filt_state = FV_W'(y);
        v = (y + longint'(center_q) * US_ONE) / US_ONE;
        if (v > longint'(max_us_q))
            v = longint'(max_us_q);
        if (v < longint'(min_us_q))
            v = longint'(min_us_q);
        return US_W'(v);
    endfunction

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // angle beats
    always @(posedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            src_gap     <= 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                channel_expected.push_back(shape_angle(in_if.angle, in_if.zero_request));
                n_in_beats++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (src_gap != 0) begin
                    src_gap     <= src_gap - 1;
                    in_if.valid <= 1'b0;
                end else if (idle_en && beats_pending.size() != 0
                             && $urandom_range(0, 7) == 0) begin
                    src_gap     <= $urandom_range(0, 5);
                    in_if.valid <= 1'b0;
                end else if (beats_pending.size() != 0) begin
                    next_beat          = beats_pending.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.angle        <= next_beat.angle;
                    in_if.zero_request <= next_beat.zero_request;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // one long receiver stall once traffic is flowing
    always @(posedge clk) begin
        if (!rst_n) begin
            long_hold      <= 0;
            long_hold_done <= 1'b0;
        end else if (long_hold != 0) begin
            long_hold <= long_hold - 1;
        end else if (!long_hold_done && n_in_beats >= LONG_HOLD_AT) begin
            long_hold      <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
    end

    // channel beats
    always @(posedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            sink_gap     <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_checked++;
                if (channel_expected.size() == 0) begin
                    $error("channel_us: no beat expected, got %0d", out_if.channel_us);
                    n_err++;
                end else begin
                    want_us = channel_expected.pop_front();
                    if (out_if.channel_us !== want_us) begin
                        $error("channel_us: expected %0d, got %0d", want_us, out_if.channel_us);
                        n_err++;
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap     <= sink_gap - 1;
                out_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                sink_gap     <= $urandom_range(0, 5);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= (long_hold == 0);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            quiet <= 0;
        end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                     || (cfg_if.valid && cfg_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("angle_to_channel_shaper test failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_beat(input logic signed [ANGLE_W-1:0] a, input logic z);
        t_beat bt;
        bt.angle        = a;
        bt.zero_request = z;
        beats_pending.push_back(bt);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_checked < n_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // called on a clock edge; valid stays high across back-to-back writes
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            REG_GAIN:    gain_q    = val[GAIN_W-1:0];
            REG_REVERSE: reverse_q = val[0];
            REG_BETA:    beta_q    = val[BETA_W-1:0];
            REG_CENTER:  center_q  = val[US_W-1:0];
            REG_MIN:     min_us_q  = val[US_W-1:0];
            REG_MAX:     max_us_q  = val[US_W-1:0];
            REG_WRAP:    wrap_q    = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] g, r, b, c, lo, hi, w,
                             input bit spare);
        write_reg(REG_GAIN, g);
        write_reg(REG_REVERSE, r);
        write_reg(REG_BETA, b);
        write_reg(REG_CENTER, c);
        write_reg(REG_MIN, lo);
        write_reg(REG_MAX, hi);
        write_reg(REG_WRAP, w);
        if (spare)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom()));
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] g;
        logic [CFG_DATA_W-1:0] b;
        logic [CFG_DATA_W-1:0] c;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        int                    walk;
        logic signed [ANGLE_W-1:0] a;

        rst_n               = 1'b0;
        in_if.valid         = 1'b0;
        in_if.angle         = '0;
        in_if.zero_request  = 1'b0;
        out_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        gain_q     = GAIN_RST;
        reverse_q  = 1'b0;
        beta_q     = BETA_RST;
        center_q   = CENTER_RST;
        min_us_q   = MIN_RST;
        max_us_q   = MAX_RST;
        wrap_q     = 1'b0;
        angle_zero = '0;
        filt_state = '0;
        walk       = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes and a re-zero
        push_beat(16'sd0, 1'b0);
        push_beat(16'sh7FFF, 1'b0);
        push_beat(16'sh8000, 1'b0);
        push_beat(16'sd64, 1'b0);
        push_beat(-16'sd64, 1'b0);
        push_beat(16'sd5000, 1'b1);
        push_beat(16'sd5000, 1'b0);
        push_beat(16'sd5100, 1'b0);
        wait_drained();

        // full gain, reversed, beta above range, wrap on, half-turn boundary
        write_all(12'd4095, 12'd1, 12'd127, 12'd2048, 12'd0, 12'd4095, 12'd1, 1'b1);
        push_beat(16'sh8000, 1'b1);
        push_beat(16'sh7FFF, 1'b0);
        push_beat(16'sd0, 1'b0);
        push_beat(-16'sd21248, 1'b0);
        push_beat(-16'sd21249, 1'b0);
        push_beat(-16'sd21247, 1'b0);
        wait_drained();

        // filter frozen, limits crossed, widest unfolded difference
        write_all(12'd4095, 12'd0, 12'd0, 12'd4095, 12'd3000, 12'd100, 12'd0, 1'b0);
        push_beat(16'sd1000, 1'b0);
        push_beat(16'sh8000, 1'b1);
        push_beat(16'sh7FFF, 1'b0);
        wait_drained();

        write_all(12'd4095, 12'd1, 12'd1, 12'd0, 12'd0, 12'd4095, 12'd0, 1'b0);
        push_beat(16'sh7FFF, 1'b0);
        push_beat(16'sh8000, 1'b0);
        wait_drained();

        for (int p = 0; p < N_RAND_PHASES; p++) begin
            if (p == N_RAND_PHASES - 1)
                idle_en = 1'b0;
            case ($urandom_range(0, 3))
                0:       g = 12'd0;
                1:       g = 12'd4095;
                default: g = CFG_DATA_W'($urandom_range(1, 640));
            endcase
            case ($urandom_range(0, 5))
                0:       b = 12'd0;
                1:       b = 12'd100;
                2:       b = CFG_DATA_W'($urandom_range(101, 127));
                3:       b = 12'd1;
                default: b = CFG_DATA_W'($urandom_range(1, 100));
            endcase
            b = b | CFG_DATA_W'($urandom_range(0, 31) << BETA_W);
            case ($urandom_range(0, 3))
                0:       c = 12'd0;
                1:       c = 12'd4095;
                default: c = CFG_DATA_W'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 4))
                0: begin
                    lo = CFG_DATA_W'($urandom_range(2000, 4095));
                    hi = CFG_DATA_W'($urandom_range(0, lo - 1));
                end
                1: begin
                    lo = 12'd0;
                    hi = 12'd4095;
                end
                default: begin
                    lo = CFG_DATA_W'($urandom_range(0, 2000));
                    hi = CFG_DATA_W'($urandom_range(lo, 4095));
                end
            endcase
            write_all(g, CFG_DATA_W'($urandom()), b, c, lo, hi, CFG_DATA_W'($urandom()),
                      $urandom_range(0, 2) == 0);
            for (int i = 0; i < BEATS_PER_PHASE; i++) begin
                case ($urandom_range(0, 9))
                    0:       a = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                    1, 2, 3: a = ANGLE_W'($urandom());
                    default: begin
                        walk = walk + int'($urandom_range(0, 400)) - 200;
                        a    = ANGLE_W'(walk);
                    end
                endcase
                push_beat(a, $urandom_range(0, 15) == 0);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_err == 0 && channel_expected.size() == 0)
            $display("angle_to_channel_shaper test passed");
        else
            $display("angle_to_channel_shaper test failed");
        $finish;
    end

endmodule
